FILE: src/apct_pkg.sv
// Package for the AABB pair contact tracker.
// Holds the item and result word types, the event codes and the fixed sizes.
// Used by src/aabb_pair_contact_tracker.sv; it depends on nothing else.
package apct_pkg;

    localparam int ID_W        = 6;
    localparam int LAYER_W     = 4;
    localparam int COORD_W     = 16;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CFG_REGS = 4;
    localparam int ROWS_PER_REG = 4;
    localparam int MASK_ROWS   = 16;
    localparam int MASK_COLS   = 16;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } contact_event_t;

    typedef struct packed {
        logic [ID_W-1:0]           first_id;
        logic [ID_W-1:0]           second_id;
        logic [LAYER_W-1:0]        first_layer;
        logic [LAYER_W-1:0]        second_layer;
        logic signed [COORD_W-1:0] first_cx;
        logic signed [COORD_W-1:0] first_cy;
        logic [COORD_W-1:0]        first_w;
        logic [COORD_W-1:0]        first_h;
        logic signed [COORD_W-1:0] second_cx;
        logic signed [COORD_W-1:0] second_cy;
        logic [COORD_W-1:0]        second_w;
        logic [COORD_W-1:0]        second_h;
    } pair_t;

    typedef struct packed {
        contact_event_t contact_event;
        logic           overlapping;
    } result_t;

endpackage

FILE: src/apct_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; instanced by the contact tracker for its contact table.
module apct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/aabb_pair_contact_tracker.sv
// Top level of the AABB pair contact tracker: layer mask, overlap test and contact table.
// Depends on apct_pkg (types, event codes) and apct_ram (contact table storage).
//
// Stages: an accepted word enters the second stage, then gives a registered result with done.
// Throughput: one word per cycle while busy is low; the contact table is read when the word
// is taken and written back in the next cycle, with the last write forwarded to the next word.
// Reset: the mask registers clear at once; the table is then cleared one entry per cycle,
// over all MAX_COLLIDERS**2 entries (4096 by default), with busy high. Results cannot stall.
module aabb_pair_contact_tracker #(
    parameter int MAX_COLLIDERS = 64,
    parameter int NUM_LAYERS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  apct_pkg::pair_t               pair,
    output logic                          done,
    output apct_pkg::result_t             result,
    input  logic                          cfg_we,
    input  logic [apct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [apct_pkg::CFG_W-1:0]    cfg_data
);

    localparam int DEPTH  = MAX_COLLIDERS * MAX_COLLIDERS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CALC_W = apct_pkg::ID_W + 11;
    localparam int LCMP_W = apct_pkg::LAYER_W + 1;
    localparam int DIFF_W = apct_pkg::COORD_W + 1;

    // Layer mask, one 16-bit row per row layer.
    logic [apct_pkg::MASK_ROWS-1:0][apct_pkg::MASK_COLS-1:0] mask_reg;

    // Table clearing after reset.
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Second stage: the word whose table entry is being read.
    logic                  s1_valid_reg;
    logic                  s1_live_reg;
    logic [AW-1:0]         s1_addr_reg;
    apct_pkg::pair_t       s1_pair_reg;

    // Last table write, forwarded to the next word.
    logic                  fwd_we_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic                  fwd_data_reg;

    logic                  done_reg;
    apct_pkg::result_t     result_reg;
    apct_pkg::result_t     result_next;

    logic                  accept;
    logic [CALC_W-1:0]     addr_calc;
    logic [AW-1:0]         rd_addr;
    logic                  live;
    logic                  rd_data;
    logic                  was;
    logic                  hit;
    logic                  hit_x;
    logic                  hit_y;
    logic                  item_we;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic                  ram_wdata;

    assign accept = start && !busy;
    assign busy   = clearing_reg;

    assign addr_calc = CALC_W'(pair.first_id) * CALC_W'(MAX_COLLIDERS)
                     + CALC_W'(pair.second_id);
    assign rd_addr   = addr_calc[AW-1:0];

    assign live = (CALC_W'(pair.first_id) < CALC_W'(MAX_COLLIDERS))
               && (CALC_W'(pair.second_id) < CALC_W'(MAX_COLLIDERS))
               && (LCMP_W'(pair.first_layer) < LCMP_W'(NUM_LAYERS))
               && (LCMP_W'(pair.second_layer) < LCMP_W'(NUM_LAYERS))
               && (pair.first_id != pair.second_id)
               && mask_reg[pair.first_layer][pair.second_layer];

    // Mask writes; an index past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            for (int r = 0; r < apct_pkg::NUM_CFG_REGS; r++)
            begin
                if (cfg_index == apct_pkg::CFG_IDX_W'(r))
                begin
                    for (int k = 0; k < apct_pkg::ROWS_PER_REG; k++)
                    begin
                        mask_reg[r * apct_pkg::ROWS_PER_REG + k] <=
                            cfg_data[k * apct_pkg::MASK_COLS +: apct_pkg::MASK_COLS];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_we_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_we_reg   <= item_we;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_live_reg  <= live;
        s1_addr_reg  <= rd_addr;
        s1_pair_reg  <= pair;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= hit;
        result_reg   <= result_next;
    end

    apct_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_contact_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Overlap on one axis: 2*|ca - cb| < sa + sb, all exact.
    function automatic logic axis_hit(
        input logic signed [apct_pkg::COORD_W-1:0] ca,
        input logic signed [apct_pkg::COORD_W-1:0] cb,
        input logic [apct_pkg::COORD_W-1:0]        sa,
        input logic [apct_pkg::COORD_W-1:0]        sb
    );
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        mag;
        logic [DIFF_W:0]          sum;
        d   = DIFF_W'(ca) - DIFF_W'(cb);
        mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        sum = (DIFF_W + 1)'(sa) + (DIFF_W + 1)'(sb);
        return {mag, 1'b0} < sum;
    endfunction

    assign hit_x = axis_hit(s1_pair_reg.first_cx, s1_pair_reg.second_cx,
                            s1_pair_reg.first_w, s1_pair_reg.second_w);
    assign hit_y = axis_hit(s1_pair_reg.first_cy, s1_pair_reg.second_cy,
                            s1_pair_reg.first_h, s1_pair_reg.second_h);
    assign hit   = hit_x && hit_y;

    // The RAM returns the old bit when the previous word wrote the same entry.
    assign was = (fwd_we_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;

    assign item_we = s1_valid_reg && s1_live_reg && (hit || was);

    always_comb
    begin
        result_next.contact_event = apct_pkg::EV_NONE;
        result_next.overlapping   = 1'b0;
        if (s1_live_reg)
        begin
            priority if (hit)
            begin
                result_next.overlapping   = 1'b1;
                result_next.contact_event = was ? apct_pkg::EV_STAY : apct_pkg::EV_ENTER;
            end
            else if (was)
            begin
                result_next.contact_event = apct_pkg::EV_EXIT;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = item_we;
            ram_waddr = s1_addr_reg;
            ram_wdata = hit;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_no_result_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) busy |-> !done
    ) else $error("result strobe while table clears");

    a_result_follows_accept : assert property (
        @(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##2 done
    ) else $error("accepted word gave no result two cycles later");

    a_event_matches_overlap : assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (result.overlapping ==
                  ((result.contact_event == apct_pkg::EV_ENTER)
                   || (result.contact_event == apct_pkg::EV_STAY)))
    ) else $error("event code disagrees with overlap flag");

    a_clear_runs_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clr_cnt_reg) == AW'(DEPTH - 1))
    ) else $error("table clear ended early");

    a_no_item_write_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) clearing_reg |-> !item_we
    ) else $error("item write collides with table clear");

endmodule
